// ===== hw/rtl/occupancy_grid_obstacle_inflation_assert.svh =====
// Assertion macros for the obstacle inflation block.
// Both expect i_clk and i_rst_n in the scope where they are used.
`ifndef OCCUPANCY_GRID_OBSTACLE_INFLATION_ASSERT_SVH
`define OCCUPANCY_GRID_OBSTACLE_INFLATION_ASSERT_SVH

`ifndef SYNTH

`define OGOI_ASSERT(name, expr) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("%m failed");

`define OGOI_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m failed");

`else

`define OGOI_ASSERT(name, expr)

`define OGOI_NEXT(name, ante, cons)

`endif

`endif

// ===== hw/rtl/ogoi_pkg.sv =====
package ogoi_pkg;

    // Item field widths
    localparam int REQ_W = 2;
    localparam int PT_W  = 17;
    localparam int KI_W  = 4;
    localparam int KV_W  = 7;
    localparam int CI_W  = 16;
    localparam int CV_W  = 7;

    // Configuration port
    localparam int CFG_W    = 9;
    localparam int CFG_A_W  = 2;
    localparam int KS_CFG_W = 4;

    localparam logic [CFG_A_W-1:0] CFG_MAP_WIDTH   = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_MAP_HEIGHT  = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_KERNEL_SIZE = 2'd2;

    localparam logic [CFG_W-1:0]    RST_MAP_WIDTH   = 9'd200;
    localparam logic [CFG_W-1:0]    RST_MAP_HEIGHT  = 9'd200;
    localparam logic [KS_CFG_W-1:0] RST_KERNEL_SIZE = 4'd9;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STAMP = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd3;

    // Full occupancy
    localparam logic [CV_W-1:0] PEAK_VAL = 7'd100;

    typedef struct packed {
        logic latch;
        logic clr_step;
        logic kload;
        logic rd_issue;
        logic chk;
        logic idx;
        logic idxchk;
        logic peak;
        logic colstep;
        logic issue;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             clr_last;
        logic             pass_ok;
        logic             k_zero;
        logic             b_zero;
        logic             cnt_last;
        logic             run_last;
    } t_stat;

endpackage

// ===== hw/rtl/ogoi_req_if.sv =====
interface ogoi_req_if import ogoi_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [REQ_W-1:0]        req_type;
    logic signed [PT_W-1:0]  point_x;
    logic signed [PT_W-1:0]  point_y;
    logic [KI_W-1:0]         kernel_row;
    logic [KI_W-1:0]         kernel_col;
    logic [KV_W-1:0]         kernel_value;
    logic [CI_W-1:0]         cell_index;

    modport source (
        output valid, req_type, point_x, point_y, kernel_row, kernel_col,
               kernel_value, cell_index,
        input  ready
    );

    modport sink (
        input  valid, req_type, point_x, point_y, kernel_row, kernel_col,
               kernel_value, cell_index,
        output ready
    );
endinterface

// ===== hw/rtl/ogoi_rsp_if.sv =====
interface ogoi_rsp_if import ogoi_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CV_W-1:0] cell_value;
    logic            point_stamped;

    modport source (
        output valid, cell_value, point_stamped,
        input  ready
    );

    modport sink (
        input  valid, cell_value, point_stamped,
        output ready
    );
endinterface

// ===== hw/rtl/ogoi_ctrl.sv =====
module ogoi_ctrl import ogoi_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DEC     = 4'd2;
    localparam logic [3:0] S_CLR     = 4'd3;
    localparam logic [3:0] S_IDX     = 4'd4;
    localparam logic [3:0] S_IDXCHK  = 4'd5;
    localparam logic [3:0] S_PEAK    = 4'd6;
    localparam logic [3:0] S_COLINIT = 4'd7;
    localparam logic [3:0] S_RUN     = 4'd8;
    localparam logic [3:0] S_DRAIN   = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_INIT: begin
                // sweep the map to zero after reset
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = !r_out_valid || i_out_ready;
                if (o_in_ready && i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DEC;
                end
            end
            S_DEC: begin
                case (i_stat.req_type)
                    REQ_CLEAR: begin
                        n_state = S_CLR;
                    end
                    REQ_LOAD: begin
                        o_cmd.kload = 1'b1;
                        n_state     = S_DONE;
                    end
                    REQ_STAMP: begin
                        o_cmd.chk = 1'b1;
                        n_state   = S_IDX;
                    end
                    REQ_READ: begin
                        o_cmd.rd_issue = 1'b1;
                        n_state        = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_DONE;
                end
            end
            S_IDX: begin
                o_cmd.idx = 1'b1;
                n_state   = S_IDXCHK;
            end
            S_IDXCHK: begin
                o_cmd.idxchk = 1'b1;
                n_state      = S_PEAK;
            end
            S_PEAK: begin
                o_cmd.peak = 1'b1;
                if (!i_stat.pass_ok || i_stat.k_zero) begin
                    n_state = S_DONE;
                end else if (i_stat.b_zero) begin
                    n_state = S_RUN;
                end else begin
                    n_state = S_COLINIT;
                end
            end
            S_COLINIT: begin
                o_cmd.colstep = 1'b1;
                if (i_stat.cnt_last) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                if (i_stat.run_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last write lands this cycle
                n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.done  = 1'b1;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/ogoi_dp.sv =====
module ogoi_dp import ogoi_pkg::*; #(
    parameter int MAP_DIM    = 256,
    parameter int KERNEL_MAX = 15,
    parameter int FRAC_BITS  = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    input  logic                   i_cfg_we,
    input  logic [CFG_A_W-1:0]     i_cfg_addr,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    input  logic [REQ_W-1:0]       i_req_type,
    input  logic signed [PT_W-1:0] i_point_x,
    input  logic signed [PT_W-1:0] i_point_y,
    input  logic [KI_W-1:0]        i_kernel_row,
    input  logic [KI_W-1:0]        i_kernel_col,
    input  logic [KV_W-1:0]        i_kernel_value,
    input  logic [CI_W-1:0]        i_cell_index,
    output logic [CV_W-1:0]        o_cell_value,
    output logic                   o_point_stamped
);

    localparam int DEPTH  = MAP_DIM * MAP_DIM;
    localparam int AW     = $clog2(DEPTH);
    localparam int DIM_W  = $clog2(MAP_DIM + 1);
    localparam int AREA_W = $clog2(DEPTH + 1);
    localparam int IXW    = $clog2(MAP_DIM * (MAP_DIM + 1) + 1);
    localparam int SW     = IXW + 2;
    localparam int KD     = KERNEL_MAX * KERNEL_MAX;
    localparam int KAW    = $clog2(KD);
    localparam int KS_W   = $clog2(KERNEL_MAX + 1);
    localparam int BWW    = KS_W + DIM_W;
    localparam int XW     = ((PT_W + 3) > (DIM_W + FRAC_BITS + 2)) ?
                            (PT_W + 3) : (DIM_W + FRAC_BITS + 2);
    localparam int EW     = (DIM_W > CFG_W) ? DIM_W : CFG_W;
    localparam int KW2    = (KS_W > KS_CFG_W) ? KS_W : KS_CFG_W;
    localparam int KRW    = (KW2 > KI_W) ? KW2 : KI_W;
    localparam int CDW    = (DIM_W > KS_W) ? DIM_W : KS_W;
    localparam int CIW    = ((CI_W > AREA_W) ? CI_W : AREA_W) + 1;

    // Configuration
    logic [CFG_W-1:0]    r_cfg_w;
    logic [CFG_W-1:0]    r_cfg_h;
    logic [KS_CFG_W-1:0] r_cfg_k;

    // Latched item
    logic [REQ_W-1:0]       r_req;
    logic signed [PT_W-1:0] r_px;
    logic signed [PT_W-1:0] r_py;
    logic [KI_W-1:0]        r_krow;
    logic [KI_W-1:0]        r_kcol;
    logic [KV_W-1:0]        r_kval;
    logic [CI_W-1:0]        r_cidx;

    // Memories
    logic [CV_W-1:0] r_map_mem [DEPTH];
    logic [CV_W-1:0] r_map_q;
    logic [KV_W-1:0] r_kmem [KD];
    logic [KV_W-1:0] r_kq;

    // Effective dimensions
    logic [DIM_W-1:0]  w_w;
    logic [DIM_W-1:0]  w_h;
    logic [KS_W-1:0]   w_k;
    logic [KS_W-1:0]   w_b;
    logic [AREA_W-1:0] r_area;

    // Stamp setup
    logic [DIM_W:0]     w_ax;
    logic [DIM_W:0]     w_ay;
    logic               r_pass;
    logic [DIM_W-1:0]   r_mx;
    logic [DIM_W-1:0]   r_my;
    logic [IXW-1:0]     r_idx;
    logic [BWW-1:0]     r_bw;
    logic [DIM_W-1:0]   r_c0;
    logic               r_idx_ok;
    logic               r_stamped;
    logic               r_rd_ok;
    logic [KS_W-1:0]    r_cnt;

    // Kernel walk
    logic signed [SW-1:0] r_row;
    logic [KS_W-1:0]      r_kr;
    logic [KS_W-1:0]      r_kc;
    logic [KAW-1:0]       r_kbase;
    logic [DIM_W-1:0]     r_col0;
    logic [DIM_W-1:0]     r_col;
    logic signed [SW-1:0] w_o;
    logic                 w_inrange;
    logic [DIM_W-1:0]     w_cd;
    logic                 w_colok;
    logic [KAW-1:0]       w_kaddr;
    logic                 w_row_end;

    // Read-modify-write stage
    logic            p_valid;
    logic [AW-1:0]   p_addr;
    logic            p_inrange;
    logic            p_colok;
    logic            r_wr_valid;
    logic [AW-1:0]   r_wr_addr;
    logic [CV_W-1:0] r_wr_data;
    logic [CV_W-1:0] w_mv;
    logic [KV_W:0]   w_sum;
    logic [CV_W-1:0] w_new;
    logic            w_upd;

    // Map port
    logic [AW-1:0]   r_clr;
    logic            w_we;
    logic [AW-1:0]   w_wa;
    logic [CV_W-1:0] w_wd;
    logic [AW-1:0]   w_ra;

    // Kernel port
    logic            w_kwe;
    logic [KAW-1:0]  w_kwa;

    // Axis cell: {dropped, cell}
    function automatic logic [DIM_W:0] f_axis(
        input logic signed [PT_W-1:0] p,
        input logic [DIM_W-1:0]       dim
    );
        logic signed [PT_W:0]   pe;
        logic [PT_W:0]          mag;
        logic [XW-1:0]          span;
        logic signed [XW-1:0]   sx;
        logic                   fail;
        pe   = p;
        mag  = pe[PT_W] ? (PT_W + 1)'(-pe) : (PT_W + 1)'(pe);
        span = XW'(dim) << FRAC_BITS;
        fail = (XW'(mag) << 1) > span;
        sx   = (XW'(pe) <<< 1) + $signed(span);
        return {fail, DIM_W'(sx >>> (FRAC_BITS + 1))};
    endfunction

    always_comb begin
        if (r_cfg_w == '0) begin
            w_w = DIM_W'(1);
        end else if (EW'(r_cfg_w) > EW'(MAP_DIM)) begin
            w_w = DIM_W'(MAP_DIM);
        end else begin
            w_w = DIM_W'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            w_h = DIM_W'(1);
        end else if (EW'(r_cfg_h) > EW'(MAP_DIM)) begin
            w_h = DIM_W'(MAP_DIM);
        end else begin
            w_h = DIM_W'(r_cfg_h);
        end
        if (KW2'(r_cfg_k) > KW2'(KERNEL_MAX)) begin
            w_k = KS_W'(KERNEL_MAX);
        end else begin
            w_k = KS_W'(r_cfg_k);
        end
    end

    assign w_b  = w_k >> 1;
    assign w_ax = f_axis(r_px, w_w);
    assign w_ay = f_axis(r_py, w_h);

    // Current kernel cell
    assign w_o       = r_row + $signed(SW'(r_kc));
    assign w_inrange = !w_o[SW-1] && (w_o[SW-2:0] < (SW - 1)'(r_area));
    assign w_cd      = (r_col >= r_c0) ? (r_col - r_c0) : (r_c0 - r_col);
    assign w_colok   = CDW'(w_cd) < CDW'(w_b);
    assign w_kaddr   = r_kbase + KAW'(r_kc);
    assign w_row_end = (r_kc == w_k - KS_W'(1));

    // Forward the previous write when the same cell comes back
    assign w_mv  = (r_wr_valid && (r_wr_addr == p_addr)) ? r_wr_data : r_map_q;
    assign w_sum = {1'b0, w_mv} + {1'b0, r_kq};
    assign w_new = (w_sum > {1'b0, PEAK_VAL}) ? PEAK_VAL : w_sum[CV_W-1:0];
    assign w_upd = p_valid && p_inrange && p_colok && (r_kq != '0) && (w_mv < r_kq);

    always_comb begin
        if (i_cmd.clr_step) begin
            w_we = 1'b1;
            w_wa = r_clr;
            w_wd = '0;
        end else begin
            w_we = w_upd;
            w_wa = p_addr;
            w_wd = w_new;
        end
        if (i_cmd.idxchk) begin
            w_ra = r_idx[AW-1:0];
        end else if (i_cmd.rd_issue) begin
            w_ra = AW'(r_cidx);
        end else begin
            w_ra = w_o[AW-1:0];
        end
    end

    assign w_kwe = i_cmd.kload && (KRW'(r_krow) < KRW'(KERNEL_MAX))
                   && (KRW'(r_kcol) < KRW'(KERNEL_MAX));
    assign w_kwa = KAW'(r_krow) * KAW'(KERNEL_MAX) + KAW'(r_kcol);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_map_mem[w_wa] <= w_wd;
        end
        r_map_q <= r_map_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_kwe) begin
            r_kmem[w_kwa] <= r_kval;
        end
        r_kq <= r_kmem[w_kaddr];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= RST_MAP_WIDTH;
            r_cfg_h    <= RST_MAP_HEIGHT;
            r_cfg_k    <= RST_KERNEL_SIZE;
            r_clr      <= '0;
            p_valid    <= 1'b0;
            r_wr_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MAP_WIDTH: begin
                        r_cfg_w <= i_cfg_wdata;
                    end
                    CFG_MAP_HEIGHT: begin
                        r_cfg_h <= i_cfg_wdata;
                    end
                    CFG_KERNEL_SIZE: begin
                        r_cfg_k <= i_cfg_wdata[KS_CFG_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.latch) begin
                r_clr <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr <= r_clr + AW'(1);
            end
            p_valid    <= i_cmd.issue;
            r_wr_valid <= w_upd;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_area    <= AREA_W'(w_w) * AREA_W'(w_h);
        r_wr_addr <= p_addr;
        r_wr_data <= w_new;
        if (i_cmd.latch) begin
            r_req  <= i_req_type;
            r_px   <= i_point_x;
            r_py   <= i_point_y;
            r_krow <= i_kernel_row;
            r_kcol <= i_kernel_col;
            r_kval <= i_kernel_value;
            r_cidx <= i_cell_index;
        end
        if (i_cmd.rd_issue) begin
            r_rd_ok <= CIW'(r_cidx) < CIW'(r_area);
        end
        if (i_cmd.chk) begin
            r_pass <= !w_ax[DIM_W] && !w_ay[DIM_W];
            r_mx   <= w_ax[DIM_W-1:0];
            r_my   <= w_ay[DIM_W-1:0];
        end
        if (i_cmd.idx) begin
            r_idx <= IXW'(r_my) * IXW'(w_w) + IXW'(r_mx);
            r_bw  <= BWW'(w_b) * BWW'(w_w);
            // column of the centre cell; mx equals the width only on the edge
            r_c0  <= (r_mx == w_w) ? '0 : r_mx;
        end
        if (i_cmd.idxchk) begin
            r_idx_ok <= (r_idx != '0)
                        && ((IXW + 1)'(r_idx) + (IXW + 1)'(1) < (IXW + 1)'(r_area));
            r_row    <= $signed(SW'(r_idx)) - $signed(SW'(w_b)) - $signed(SW'(r_bw));
            r_col0   <= r_c0;
            r_col    <= r_c0;
            r_cnt    <= w_b;
            r_kr     <= '0;
            r_kc     <= '0;
            r_kbase  <= '0;
        end
        if (i_cmd.peak) begin
            r_stamped <= o_stat.pass_ok;
        end
        if (i_cmd.colstep) begin
            // walk the starting column back by half the kernel, wrapping in the row
            r_col0 <= (r_col0 == '0) ? (w_w - DIM_W'(1)) : (r_col0 - DIM_W'(1));
            r_col  <= (r_col0 == '0) ? (w_w - DIM_W'(1)) : (r_col0 - DIM_W'(1));
            r_cnt  <= r_cnt - KS_W'(1);
        end
        if (i_cmd.issue) begin
            p_addr    <= w_o[AW-1:0];
            p_inrange <= w_inrange;
            p_colok   <= w_colok;
            if (w_row_end) begin
                r_kc    <= '0;
                r_kr    <= r_kr + KS_W'(1);
                r_row   <= r_row + $signed(SW'(w_w));
                r_kbase <= r_kbase + KAW'(KERNEL_MAX);
                r_col   <= r_col0;
            end else begin
                r_kc  <= r_kc + KS_W'(1);
                r_col <= (r_col == w_w - DIM_W'(1)) ? '0 : (r_col + DIM_W'(1));
            end
        end
        if (i_cmd.done) begin
            o_cell_value    <= ((r_req == REQ_READ) && r_rd_ok) ? r_map_q : '0;
            o_point_stamped <= (r_req == REQ_STAMP) && r_stamped;
        end
    end

    assign o_stat.req_type = r_req;
    assign o_stat.clr_last = (r_clr == AW'(DEPTH - 1));
    assign o_stat.pass_ok  = r_pass && r_idx_ok && (r_map_q != PEAK_VAL);
    assign o_stat.k_zero   = (w_k == '0);
    assign o_stat.b_zero   = (w_b == '0);
    assign o_stat.cnt_last = (r_cnt == KS_W'(1));
    assign o_stat.run_last = w_row_end && (r_kr == w_k - KS_W'(1));

endmodule

// ===== hw/rtl/occupancy_grid_obstacle_inflation.sv =====
// Obstacle inflation over a stored occupancy grid of MAP_DIM x MAP_DIM cells, one item at a
// time. A stamp walks the K x K kernel over the map; the map memory has one read and one write
// port, so one kernel cell is read, updated and written back each cycle, with the previous
// write forwarded when two kernel cells land on the same map cell.
// A dropped point or a zero kernel ends the stamp without walking the kernel.
// A clear walks the whole map, one cell per cycle. After reset the same clearing pass runs
// and no item is accepted until it ends; configuration writes are taken throughout. The
// result of an item sits in an output register, and the next item can be accepted in the
// cycle that result is taken.
module occupancy_grid_obstacle_inflation import ogoi_pkg::*; #(
    parameter int MAP_DIM    = 256,
    parameter int KERNEL_MAX = 15,
    parameter int FRAC_BITS  = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_A_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    ogoi_req_if.sink           i_req,
    ogoi_rsp_if.source         o_rsp
);

    `include "occupancy_grid_obstacle_inflation_assert.svh"

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;
    logic  w_out_valid;

    ogoi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    ogoi_dp #(
        .MAP_DIM    (MAP_DIM),
        .KERNEL_MAX (KERNEL_MAX),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_req_type      (i_req.req_type),
        .i_point_x       (i_req.point_x),
        .i_point_y       (i_req.point_y),
        .i_kernel_row    (i_req.kernel_row),
        .i_kernel_col    (i_req.kernel_col),
        .i_kernel_value  (i_req.kernel_value),
        .i_cell_index    (i_req.cell_index),
        .o_cell_value    (o_rsp.cell_value),
        .o_point_stamped (o_rsp.point_stamped)
    );

    assign i_req.ready = w_in_ready;
    assign o_rsp.valid = w_out_valid;

    `OGOI_ASSERT(a_walk_blocks_input, !(w_cmd.issue && i_req.ready))
    `OGOI_NEXT(a_accept_drops_ready, i_req.valid && i_req.ready, !i_req.ready)
    `OGOI_NEXT(a_done_shows_result, w_cmd.done, o_rsp.valid)
    `OGOI_NEXT(a_done_single_cycle, w_cmd.done, !w_cmd.done)

endmodule
